/* rtl/plnmf_pkg.sv */
// ============================================================================
// plnmf_pkg: shared constants and types of the plus-shaped mean filter
// Frame limits, configuration register indexes, divisor codes and the job
// record that travels from the front end to the result sequencer.
// ============================================================================
package plnmf_pkg;

    // Frame limits and the widths that follow from them.
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 96;
    localparam int COL_W       = $clog2(MAX_COLUMNS);      // column position
    localparam int ROW_W       = $clog2(MAX_ROWS);         // row position
    localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);  // column count
    localparam int ROWS_W      = $clog2(MAX_ROWS + 1);     // row count

    // Pixel and sum widths. Five pixels are summed at most.
    localparam int PIXEL_W = 8;
    localparam int SUM_W   = PIXEL_W + 3;

    // Configuration port.
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_COLS_W   = 8;
    localparam int CFG_ROWS_W   = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_ROWS    = 2'd1;

    // Job queue between the front end and the result sequencer.
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RESULT_SLOTS = 3;
    localparam int SLOT_W       = $clog2(RESULT_SLOTS + 1);

    typedef enum logic [1:0] {
        DIV_BY_3,
        DIV_BY_4,
        DIV_BY_5
    } div_code_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        div_code_t        div;
    } slot_t;

    // One accepted pixel's worth of results: count is 1 to 3, slots fill
    // from index 0, and slot 2 is always the frame's final pixel.
    typedef struct packed {
        logic [SLOT_W-1:0]              count;
        slot_t [RESULT_SLOTS-1:0]       slots;
    } job_t;

endpackage

/* rtl/plus_neighbourhood_mean_filter.sv */
// ============================================================================
// plus_neighbourhood_mean_filter: five-point cross mean over a pixel stream
// Each pixel of a raster-ordered frame is replaced by the truncated mean of
// itself and its in-frame up, down, left and right neighbours.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  ----------------------------------
//  input     in         push / full          pixel_in
//  result    out        empty / pop          pixel_out, last_of_run,
//                                            end_of_frame
//  config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One pixel beat is taken per cycle while full is low. The first row gives
//  no results, the rows after it one per pixel; the last row gives two per
//  pixel (one on its first pixel and three on the final one), and since at
//  most one result beat leaves per cycle, the result sequencer sets the pace
//  of that row. A beat's results pass the front-end registers, the job
//  queue and the output register. Reset returns to a 128 x 96 frame at its
//  first pixel; the line stores keep whatever they hold. A stall on pop
//  backs up through a four-job queue and then raises full.
//
module plus_neighbourhood_mean_filter
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [plnmf_pkg::PIXEL_W-1:0]      pixel_in,
    output logic                               empty,
    input  logic                               pop,
    output logic [plnmf_pkg::PIXEL_W-1:0]      pixel_out,
    output logic                               last_of_run,
    output logic                               end_of_frame,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [plnmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [plnmf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import plnmf_pkg::*;

    // The front end fetches the line stores one column ahead and forms all
    // sums for a pixel in the cycle after its beat; the job then waits in
    // the queue until the sequencer has emitted every result it carries.
    job_t               job;
    job_t               head;
    logic               job_push;
    logic               has_job;
    logic               job_done;
    logic [LEVEL_W-1:0] q_level;

    plnmf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel_in  (pixel_in),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_level   (q_level),
        .job_push  (job_push),
        .job       (job)
    );

    plnmf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .job_in    (job),
        .pop       (job_done),
        .head      (head),
        .not_empty (has_job),
        .level     (q_level)
    );

    // The sequencer owns the output register, so a waiting result never
    // holds up the front end while the queue has room.
    plnmf_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .has_job      (has_job),
        .job_done     (job_done),
        .empty        (empty),
        .pop          (pop),
        .pixel_out    (pixel_out),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame)
    );

endmodule

/* rtl/plnmf_front.sv */
// ============================================================================
// plnmf_front: pixel intake, line stores and neighbourhood sums
// Accepts pixels, tracks the raster position, keeps the two line stores and
// turns each pixel into a job of up to three sums with their divisors.
// ============================================================================
module plnmf_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [plnmf_pkg::PIXEL_W-1:0]      pixel_in,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [plnmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [plnmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [plnmf_pkg::LEVEL_W-1:0]      q_level,
    output logic                               job_push,
    output plnmf_pkg::job_t                    job
);
    import plnmf_pkg::*;

    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic last_col;
        logic last_row;
    } pos_flags_t;

    logic [COLS_W-1:0]  cols_reg;
    logic [ROWS_W-1:0]  rows_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic               s1_valid_reg;
    pos_flags_t         s1_flags_reg;
    logic [PIXEL_W-1:0] s1_pix_reg;
    logic [PIXEL_W-1:0] s1_pix_prev_reg;
    logic [PIXEL_W-1:0] s1_pix_prev2_reg;
    logic [PIXEL_W-1:0] s1_centre_reg;
    logic [PIXEL_W-1:0] s1_left_up_reg;
    logic [PIXEL_W-1:0] rd_recent_reg;
    logic [PIXEL_W-1:0] rd_older_reg;
    logic [PIXEL_W-1:0] recent_row_store_mem [MAX_COLUMNS];
    logic [PIXEL_W-1:0] older_row_store_mem  [MAX_COLUMNS];

    logic               accept;
    logic               cfg_write;
    logic               last_col;
    logic               last_row;
    logic [COL_W-1:0]   rd_addr;
    pos_flags_t         flags;
    logic [COLS_W-1:0]  cols_next;
    logic [ROWS_W-1:0]  rows_next;
    logic [1:0]         optional_count;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready
                       && (cfg_index == CFG_ACTIVE_COLUMNS || cfg_index == CFG_ACTIVE_ROWS);

    // The job queue must have room for the pixel already in flight.
    assign full   = ((LEVEL_W + 1)'(q_level) + (LEVEL_W + 1)'(s1_valid_reg))
                    >= (LEVEL_W + 1)'(QUEUE_DEPTH);
    assign accept = push && !full;

    assign last_col = (COLS_W'(col_reg) + COLS_W'(1)) == cols_reg;
    assign last_row = (ROWS_W'(row_reg) + ROWS_W'(1)) == rows_reg;

    // The column after this one is fetched ahead; at the row end that is
    // column 0 of the next row.
    assign rd_addr = last_col ? '0 : col_reg + COL_W'(1);

    always_comb
    begin
        flags.row_ge1  = (row_reg != '0);
        flags.row_ge2  = (row_reg > ROW_W'(1));
        flags.col_ge1  = (col_reg != '0);
        flags.col_ge2  = (col_reg > COL_W'(1));
        flags.last_col = last_col;
        flags.last_row = last_row;
    end

    // Register values are saturated into the supported range when written.
    always_comb
    begin
        if (cfg_data[CFG_COLS_W-1:0] < CFG_COLS_W'(2))
            cols_next = COLS_W'(2);
        else if (int'(cfg_data[CFG_COLS_W-1:0]) > MAX_COLUMNS)
            cols_next = COLS_W'(MAX_COLUMNS);
        else
            cols_next = COLS_W'(cfg_data[CFG_COLS_W-1:0]);

        if (cfg_data[CFG_ROWS_W-1:0] < CFG_ROWS_W'(2))
            rows_next = ROWS_W'(2);
        else if (int'(cfg_data[CFG_ROWS_W-1:0]) > MAX_ROWS)
            rows_next = ROWS_W'(MAX_ROWS);
        else
            rows_next = ROWS_W'(cfg_data[CFG_ROWS_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= COLS_W'(MAX_COLUMNS);
            rows_reg     <= ROWS_W'(MAX_ROWS);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_flags_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
                s1_flags_reg <= flags;
            if (cfg_write)
            begin
                if (cfg_index == CFG_ACTIVE_COLUMNS)
                    cols_reg <= cols_next;
                else
                    rows_reg <= rows_next;
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // Window registers: the pixel, the two pixels before it in the row, the
    // pixel above it and the one above-left.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg       <= pixel_in;
            s1_pix_prev_reg  <= s1_pix_reg;
            s1_pix_prev2_reg <= s1_pix_prev_reg;
            s1_centre_reg    <= rd_recent_reg;
            s1_left_up_reg   <= s1_centre_reg;
        end
    end

    // Line stores. The older store takes the value the recent store held at
    // this column, which is the prefetched read data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_recent_reg                 <= recent_row_store_mem[rd_addr];
            recent_row_store_mem[col_reg] <= pixel_in;
            rd_older_reg                  <= older_row_store_mem[col_reg];
            older_row_store_mem[col_reg]  <= rd_recent_reg;
        end
    end

    // Sums for the pixel above, the pixel to the left on the last row, and
    // the last pixel of the frame.
    assign optional_count = 2'(s1_flags_reg.row_ge2) + 2'(s1_flags_reg.col_ge1)
                            + 2'(!s1_flags_reg.last_col);

    always_comb
    begin
        job.slots[0].sum = SUM_W'(s1_centre_reg) + SUM_W'(s1_pix_reg)
                         + (s1_flags_reg.row_ge2  ? SUM_W'(rd_older_reg)   : '0)
                         + (s1_flags_reg.col_ge1  ? SUM_W'(s1_left_up_reg) : '0)
                         + (!s1_flags_reg.last_col ? SUM_W'(rd_recent_reg) : '0);
        case (optional_count)
            2'd1:    job.slots[0].div = DIV_BY_3;
            2'd2:    job.slots[0].div = DIV_BY_4;
            2'd3:    job.slots[0].div = DIV_BY_5;
            default: job.slots[0].div = DIV_BY_3;
        endcase

        job.slots[1].sum = SUM_W'(s1_pix_prev_reg) + SUM_W'(s1_left_up_reg)
                         + SUM_W'(s1_pix_reg)
                         + (s1_flags_reg.col_ge2 ? SUM_W'(s1_pix_prev2_reg) : '0);
        job.slots[1].div = s1_flags_reg.col_ge2 ? DIV_BY_4 : DIV_BY_3;

        job.slots[2].sum = SUM_W'(s1_pix_reg) + SUM_W'(s1_centre_reg)
                         + SUM_W'(s1_pix_prev_reg);
        job.slots[2].div = DIV_BY_3;

        job.count = SLOT_W'(1)
                  + SLOT_W'(s1_flags_reg.last_row && s1_flags_reg.col_ge1)
                  + SLOT_W'(s1_flags_reg.last_row && s1_flags_reg.last_col);
    end

    // First-row pixels produce nothing.
    assign job_push = s1_valid_reg && s1_flags_reg.row_ge1;

endmodule

/* rtl/plnmf_queue.sv */
// ============================================================================
// plnmf_queue: job queue between front end and result sequencer
// A small first-in first-out buffer of jobs with a fill level output.
// ============================================================================
module plnmf_queue
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  plnmf_pkg::job_t                job_in,
    input  logic                           pop,
    output plnmf_pkg::job_t                head,
    output logic                           not_empty,
    output logic [plnmf_pkg::LEVEL_W-1:0]  level
);
    import plnmf_pkg::*;

    job_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic              do_pop;

    assign not_empty = (level_reg != '0);
    assign level     = level_reg;
    assign head      = entries_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + QPTR_W'(1);
            if (push && !do_pop)
                level_reg <= level_reg + LEVEL_W'(1);
            else if (!push && do_pop)
                level_reg <= level_reg - LEVEL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= job_in;
    end

endmodule

/* rtl/plnmf_back.sv */
// ============================================================================
// plnmf_back: result sequencer
// Walks the slots of the job at the queue head, divides each sum by its
// neighbour count and holds the result in the output register.
// ============================================================================
module plnmf_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  plnmf_pkg::job_t                head,
    input  logic                           has_job,
    output logic                           job_done,
    output logic                           empty,
    input  logic                           pop,
    output logic [plnmf_pkg::PIXEL_W-1:0]  pixel_out,
    output logic                           last_of_run,
    output logic                           end_of_frame
);
    import plnmf_pkg::*;

    // Reciprocals scaled by 2^16; exact truncation for any SUM_W-bit sum.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 15;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(((1 << RECIP_SHIFT) + 4) / 5);

    function automatic logic [PIXEL_W-1:0] mean_of(input logic [SUM_W-1:0] sum,
                                                   input div_code_t code);
        logic [PROD_W-1:0] prod;
        logic [PIXEL_W-1:0] res;
        prod = PROD_W'(sum) * PROD_W'((code == DIV_BY_5) ? RECIP_5 : RECIP_3);
        case (code)
            DIV_BY_3: res = prod[RECIP_SHIFT +: PIXEL_W];
            DIV_BY_4: res = sum[2 +: PIXEL_W];
            DIV_BY_5: res = prod[RECIP_SHIFT +: PIXEL_W];
            default:  res = '0;
        endcase
        return res;
    endfunction

    logic [SLOT_W-1:0]  sub_reg;
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] pixel_reg;
    logic               last_reg;
    logic               eof_reg;
    logic               take;
    logic               is_last;
    slot_t              cur_slot;

    assign cur_slot = head.slots[sub_reg];
    assign is_last  = (sub_reg == head.count - SLOT_W'(1));
    assign take     = has_job && (!out_valid_reg || pop);
    assign job_done = take && is_last;

    assign empty        = !out_valid_reg;
    assign pixel_out    = pixel_reg;
    assign last_of_run  = last_reg;
    assign end_of_frame = eof_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                sub_reg       <= is_last ? '0 : sub_reg + SLOT_W'(1);
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pixel_reg <= mean_of(cur_slot.sum, cur_slot.div);
            last_reg  <= is_last;
            eof_reg   <= (sub_reg == SLOT_W'(RESULT_SLOTS - 1));
        end
    end

endmodule

/* tb/plus_neighbourhood_mean_filter_tb.sv */
// ============================================================================
// plus_neighbourhood_mean_filter_tb: self-checking bench for the cross mean
// Streams directed and random frames through the filter under changing frame
// sizes and random handshake gaps. A scoreboard object predicts every
// filtered pixel and checks each result beat in order as it leaves the block.
// ============================================================================
module plus_neighbourhood_mean_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import plnmf_pkg::*;

    localparam int CLK_HALF = 5;

    // Register indexes that the block decodes to nothing. A write to them
    // must leave the frame position alone.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    // A first-row pixel gives no result, so the expectation queue can run dry
    // while such a pixel is still inside the block. A result of a beat passes the
    // front-end registers, the job queue and the output register, and this many
    // quiet cycles is ample for that before a register write or the end of the run.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;

    // Cycles without any accepted beat before the run is declared hung. The
    // longest legal quiet stretch is a random gap of the sender or receiver
    // (each idling at most about half the time) plus the settle pause.
    localparam int QUIET_LIMIT = 2000;

    localparam int RANDOM_ITEMS_PER_PHASE = 16;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [PIXEL_W-1:0]     pixel_in;
    logic                   empty;
    logic                   pop;
    logic [PIXEL_W-1:0]     pixel_out;
    logic                   last_of_run;
    logic                   end_of_frame;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Percent of cycles in which each side holds off.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned quiet_cycles;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of both line stores, the frame position
    // and the size registers, and queues the filtered pixels that each
    // accepted input beat must produce.
    // ------------------------------------------------------------------------
    class cross_mean_checker;

        typedef struct packed {
            logic [PIXEL_W-1:0] pixel;
            logic               run_end;
            logic               frame_end;
        } filtered_t;

        logic [PIXEL_W-1:0]    older_line [MAX_COLUMNS];
        logic [PIXEL_W-1:0]    recent_line [MAX_COLUMNS];
        logic [PIXEL_W-1:0]    prev_pixel;
        int unsigned           row_pos;
        int unsigned           col_pos;
        logic [CFG_COLS_W-1:0] columns_reg;
        logic [CFG_ROWS_W-1:0] rows_reg;
        filtered_t             expected_pixels [$];
        int unsigned           mismatches;

        function new();
            foreach (older_line[i]) begin
                older_line[i]  = '0;
                recent_line[i] = '0;
            end
            prev_pixel  = '0;
            row_pos     = 0;
            col_pos     = 0;
            columns_reg = CFG_COLS_W'(MAX_COLUMNS);
            rows_reg    = CFG_ROWS_W'(MAX_ROWS);
            mismatches  = 0;
        endfunction

        // Any decoded write restarts the frame; the line stores keep their data.
        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == CFG_ACTIVE_COLUMNS)
                columns_reg = data[CFG_COLS_W-1:0];
            else if (index == CFG_ACTIVE_ROWS)
                rows_reg = data[CFG_ROWS_W-1:0];
            else
                return;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void take_pixel(logic [PIXEL_W-1:0] p);
            int unsigned cols;
            int unsigned rows;
            int unsigned r;
            int unsigned c;
            int unsigned sum;
            int unsigned n;
            int unsigned before_count;
            bit          last_row;
            bit          last_col;
            // Out-of-range sizes saturate into the supported span.
            cols = (columns_reg < 2) ? 2 :
                   (columns_reg > MAX_COLUMNS) ? MAX_COLUMNS : columns_reg;
            rows = (rows_reg < 2) ? 2 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
            r = row_pos;
            c = col_pos;
            last_row = (r + 1 == rows);
            last_col = (c + 1 == cols);
            if (r >= rows || c >= cols) begin
                r = 0;
                c = 0;
                last_row = 1'b0;
                last_col = 1'b0;
            end
            before_count = expected_pixels.size();

            // The pixel below completes the one above it.
            if (r >= 1) begin
                sum = recent_line[c] + p;
                n   = 2;
                if (r >= 2) begin
                    sum += older_line[c];
                    n++;
                end
                if (c >= 1) begin
                    sum += older_line[c - 1];
                    n++;
                end
                if (!last_col) begin
                    sum += recent_line[c + 1];
                    n++;
                end
                expected_pixels.push_back('{8'(sum / n), 1'b0, 1'b0});
            end

            older_line[c]  = recent_line[c];
            recent_line[c] = p;

            // On the bottom row the pixel to the right completes its left
            // neighbour, and the final pixel completes itself.
            if (last_row && c >= 1) begin
                sum = prev_pixel + older_line[c - 1] + p;
                n   = 3;
                if (c >= 2) begin
                    sum += recent_line[c - 2];
                    n++;
                end
                expected_pixels.push_back('{8'(sum / n), 1'b0, 1'b0});
            end
            if (last_row && last_col) begin
                sum = p + older_line[c] + recent_line[c - 1];
                expected_pixels.push_back('{8'(sum / 3), 1'b0, 1'b1});
            end
            if (expected_pixels.size() > before_count)
                expected_pixels[expected_pixels.size() - 1].run_end = 1'b1;

            prev_pixel = p;
            if (last_col) begin
                col_pos = 0;
                row_pos = last_row ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function void check_pixel(logic [PIXEL_W-1:0] pixel, logic run_end,
                                  logic frame_end);
            filtered_t want;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result beat with nothing expected: pixel %0d last %0b eof %0b",
                             $realtime, pixel, run_end, frame_end);
                return;
            end
            want = expected_pixels.pop_front();
            if (want.pixel !== pixel || want.run_end !== run_end ||
                want.frame_end !== frame_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result differs: pixel %0d/%0d last %0b/%0b eof %0b/%0b (expected/actual)",
                             $realtime, want.pixel, pixel, want.run_end, run_end,
                             want.frame_end, frame_end);
            end
        endfunction

        function int unsigned outstanding();
            return expected_pixels.size();
        endfunction

    endclass

    cross_mean_checker board;

    plus_neighbourhood_mean_filter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_in     (pixel_in),
        .empty        (empty),
        .pop          (pop),
        .pixel_out    (pixel_out),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Every handshake is observed at the rising edge, where the inputs have
    // been steady since the falling edge. Results are checked before the
    // input beat of the same edge is noted: a pixel can never produce a
    // result in the cycle that accepts it.
    always @(posedge clk)
    begin
        if (rst_n) begin
            quiet_cycles++;
            if (pop && !empty) begin
                board.check_pixel(pixel_out, last_of_run, end_of_frame);
                quiet_cycles = 0;
            end
            if (push && !full) begin
                board.take_pixel(pixel_in);
                quiet_cycles = 0;
            end
            if (cfg_valid && cfg_ready) begin
                board.write_register(cfg_index, cfg_data);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%t: no beat accepted for %0d cycles", $realtime, QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // The receiver decides once per cycle, at the falling edge, whether to
    // take the result that may be waiting.
    initial
    begin
        pop = 1'b0;
        forever begin
            @(negedge clk);
            pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // All driving tasks start and end at a falling edge.

    // Offer one pixel beat, after a random hold-off, and return once taken.
    // Push stays high on return so that back-to-back beats have no bubble.
    task automatic push_pixel(input logic [PIXEL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        pixel_in <= value;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One register beat. Valid is left high; the caller lowers it after its
    // last write so that consecutive writes run without a gap.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Let the block run empty: every predicted result out, then a pause for
    // any first-row pixel that is still on its way through.
    task automatic drain();
        push <= 1'b0;
        while (board.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] cols_val,
                             input logic [CFG_DATA_W-1:0] rows_val);
        drain();
        write_reg(CFG_ACTIVE_COLUMNS, cols_val);
        write_reg(CFG_ACTIVE_ROWS, rows_val);
        cfg_valid <= 1'b0;
    endtask

    // Random pixels, with now and then a write to an unused register index
    // in the middle of the frame, which must not disturb the frame position.
    task automatic feed_random(input int count);
        logic [PIXEL_W-1:0] value;
        for (int i = 0; i < count; i++) begin
            if (i > 0 && $urandom_range(99) < 2) begin
                drain();
                write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DATA_W'($urandom_range(255)));
                cfg_valid <= 1'b0;
            end
            // Saturated pixels, all zeros or all ones, push the sums to their extremes.
            if ($urandom_range(7) == 0)
                value = {PIXEL_W{1'($urandom_range(1))}};
            else
                value = PIXEL_W'($urandom_range(255));
            push_pixel(value);
        end
    endtask

    // Mostly complete small frames, so that every border case and the
    // triple-result end of frame come round often. About one frame in eight
    // is cut short by the next size change, which restarts the frame.
    task automatic run_random(input int budget);
        int unsigned cols;
        int unsigned rows;
        int unsigned len;
        int          fed;
        logic [CFG_DATA_W-1:0] cols_val;
        logic [CFG_DATA_W-1:0] rows_val;
        fed = 0;
        while (fed < budget) begin
            if ($urandom_range(7) == 0) begin
                cols = $urandom_range(40, 10);
                rows = $urandom_range(3, 2);
            end else begin
                cols = $urandom_range(9, 2);
                rows = $urandom_range(6, 2);
            end
            // A size of two may also be asked for as zero or one, which the
            // block saturates. Bit 7 of a row write is not part of the register.
            cols_val = (cols == 2 && $urandom_range(1)) ? CFG_DATA_W'($urandom_range(1))
                                                        : CFG_DATA_W'(cols);
            rows_val[6:0] = (rows == 2 && $urandom_range(1)) ? 7'($urandom_range(1))
                                                             : 7'(rows);
            rows_val[7] = 1'($urandom_range(1));
            len = cols * rows;
            if ($urandom_range(7) == 0)
                len = $urandom_range(len - 1, 1);
            set_frame(cols_val, rows_val);
            feed_random(len);
            fed += len;
        end
    endtask

    initial
    begin
        board         = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pixel_in      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_ACTIVE_COLUMNS;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles  = 0;

        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, without idling on either side.

        // Smallest frame, both sizes given below range: all four pixels are
        // corners, so each result is a mean of three.
        set_frame(8'd0, 8'd1);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd0);
        push_pixel(8'd255);

        // All-white 3 x 3: the centre sums five full-scale pixels.
        set_frame(8'd3, 8'd3);
        repeat (9)
            push_pixel(8'd255);

        // A frame interrupted by a write to an unused index, which must not
        // restart it, and then abandoned by a real size change.
        set_frame(8'd4, 8'd3);
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd17);
        push_pixel(8'd200);
        push_pixel(8'd99);
        drain();
        write_reg(CFG_SPARE_A, 8'hA5);
        cfg_valid <= 1'b0;
        push_pixel(8'd255);
        push_pixel(8'd0);

        // Small values where the truncation of the divide by three shows.
        set_frame(8'd2, 8'd2);
        push_pixel(8'd1);
        push_pixel(8'd2);
        push_pixel(8'd3);
        push_pixel(8'd4);

        // Random part. First the sender rarely waits and the receiver often.
        drain();
        send_idle_pct = 8;
        recv_idle_pct = 49;
        run_random(RANDOM_ITEMS_PER_PHASE);

        // Then the other way round, starting with the widest frame, given
        // with bit 7 set.
        drain();
        send_idle_pct = 49;
        recv_idle_pct = 8;
        set_frame(8'd128, 8'd2);
        feed_random(MAX_COLUMNS * 2);
        run_random(RANDOM_ITEMS_PER_PHASE);

        // Finally full rate on both sides, starting with a tall frame asked
        // for above range so that it saturates; it is cut short after a few
        // rows by the next size change.
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_frame(8'd2, 8'hFF);
        feed_random(16);
        run_random(RANDOM_ITEMS_PER_PHASE);

        drain();
        repeat (TAIL_CYCLES)
            @(negedge clk);

        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            if (board.outstanding() != 0)
                $display("%0d expected results never arrived", board.outstanding());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/plnmf_pkg.sv
rtl/plnmf_front.sv
rtl/plnmf_queue.sv
rtl/plnmf_back.sv
rtl/plus_neighbourhood_mean_filter.sv
tb/plus_neighbourhood_mean_filter_tb.sv
